/* rtl/prs_pkg.sv */
package prs_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int MAX_EDGES    = 16384;

    localparam int VID_W   = 12;
    localparam int VADDR_W = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = VADDR_W + 1;
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ETOT_W  = EADDR_W + 1;
    localparam int DEG_W   = 15;
    localparam int RANK_W  = 33;
    localparam int DAMP_W  = 16;
    localparam int ITER_W  = 8;
    localparam int NREG_W  = 13;

    localparam logic [RANK_W-1:0] ONE_FX  = {1'b1, {(RANK_W-1){1'b0}}};
    localparam logic [DEG_W-1:0]  DEG_MAX = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_RUN      = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_VCOUNT = 2'd0,
        REG_ITER   = 2'd1,
        REG_DAMP   = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DCLR,
        S_EDGE,
        S_READ,
        S_INIT,
        S_INITZ,
        S_INITW,
        S_ARD,
        S_ASTART,
        S_AWAIT,
        S_BRD,
        S_BADR,
        S_BUPD,
        S_CRD,
        S_CMUL,
        S_CWR,
        S_FIN
    } state_t;

    typedef struct packed {
        logic              start;
        logic [RANK_W-1:0] dividend;
        logic [DEG_W-1:0]  divisor;
    } div_req_t;

    // Clamp a grown sum to 1.0
    function automatic logic [RANK_W-1:0] sat_one(input logic [RANK_W:0] x);
        logic [RANK_W-1:0] r;
        if (x > {1'b0, ONE_FX})
        begin
            r = ONE_FX;
        end
        else
        begin
            r = x[RANK_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/pagerank_edge_scatter_top.sv */
// One item at a time; the shared divider and the memories, each with one write and one read
// port, set the pace.
// Reset: registers return to defaults, then a pass over all 4096 entries clears out-degree and
// rank memories, during which no item is taken (configuration writes still work).
module pagerank_edge_scatter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      cmd,
    input  logic [prs_pkg::VID_W-1:0]       src_vertex,
    input  logic [prs_pkg::VID_W-1:0]       dst_vertex,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [prs_pkg::VID_W-1:0]       vertex,
    output logic [prs_pkg::RANK_W-1:0]      rank
);
    import prs_pkg::*;

    state_t state_reg, state_next;

    logic [NREG_W-1:0]  vcount_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [DAMP_W-1:0]  damp_reg;
    logic [VCNT_W-1:0]  n;

    logic [ETOT_W-1:0]  edge_total_reg;
    logic [ETOT_W-1:0]  eaddr_reg;
    logic [VCNT_W-1:0]  vaddr_reg;
    logic [ITER_W-1:0]  it_left_reg;
    logic [VID_W-1:0]   src_reg;
    logic [VID_W-1:0]   dst_reg;
    logic [VID_W-1:0]   t_reg;
    logic [RANK_W-1:0]  y_reg;
    logic [RANK_W-1:0]  z_reg;
    logic [RANK_W+DAMP_W-1:0] prod_reg;
    logic [RANK_W+DAMP_W:0]   zprod;
    status_t            res_status_reg;
    logic [RANK_W-1:0]  res_rank_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [VID_W-1:0]   vertex_reg;
    logic [RANK_W-1:0]  rank_reg;

    logic               accept;
    logic               cfg_we;
    logic               v_last;
    logic               e_last;
    logic               edge_ok;
    logic               out_free;
    logic [VID_W-1:0]   e_src;
    logic [VID_W-1:0]   e_dst;

    logic                     edge_we;
    logic [2*VID_W-1:0]       edge_rdata;
    logic                     deg_we;
    logic [VADDR_W-1:0]       deg_waddr, deg_raddr;
    logic [DEG_W-1:0]         deg_wdata, deg_rdata;
    logic                     rank_we;
    logic [VADDR_W-1:0]       rank_waddr, rank_raddr;
    logic [RANK_W-1:0]        rank_wdata, rank_rdata;
    logic                     sum_we;
    logic [VADDR_W-1:0]       sum_waddr, sum_raddr;
    logic [RANK_W-1:0]        sum_wdata, sum_rdata;

    div_req_t               div_req;
    logic                   div_busy;
    logic                   div_done;
    logic [RANK_W-1:0]      div_q;

    // Effective vertex count
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n = VCNT_W'(1);
        end
        else if (vcount_reg > NREG_W'(MAX_VERTICES))
        begin
            n = VCNT_W'(MAX_VERTICES);
        end
        else
        begin
            n = VCNT_W'(vcount_reg);
        end
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_we   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign v_last   = (vaddr_reg == n - 1'b1);
    assign e_last   = (eaddr_reg == edge_total_reg - 1'b1);
    assign e_src    = edge_rdata[2*VID_W-1:VID_W];
    assign e_dst    = edge_rdata[VID_W-1:0];
    assign edge_ok  = ({1'b0, e_src} < n) && ({1'b0, e_dst} < n);
    assign out_free = !out_valid_reg || out_ready;
    assign zprod    = y_reg * ((DAMP_W+1)'(1 << DAMP_W) - {1'b0, damp_reg});

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= NREG_W'(MAX_VERTICES);
            iter_reg   <= ITER_W'(20);
            damp_reg   <= DAMP_W'(55706);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_VCOUNT: vcount_reg <= pwdata[NREG_W-1:0];
                REG_ITER:   iter_reg   <= pwdata[ITER_W-1:0];
                REG_DAMP:   damp_reg   <= pwdata[DAMP_W-1:0];
                default:    ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_VCOUNT: prdata = 32'(vcount_reg);
            REG_ITER:   prdata = 32'(iter_reg);
            REG_DAMP:   prdata = 32'(damp_reg);
            default:    prdata = '0;
        endcase
    end

    // Next state and memory controls
    always_comb
    begin
        state_next = state_reg;
        edge_we    = 1'b0;
        deg_we     = 1'b0;
        deg_waddr  = vaddr_reg[VADDR_W-1:0];
        deg_wdata  = '0;
        deg_raddr  = vaddr_reg[VADDR_W-1:0];
        rank_we    = 1'b0;
        rank_waddr = vaddr_reg[VADDR_W-1:0];
        rank_wdata = '0;
        rank_raddr = vaddr_reg[VADDR_W-1:0];
        sum_we     = 1'b0;
        sum_waddr  = vaddr_reg[VADDR_W-1:0];
        sum_wdata  = '0;
        sum_raddr  = vaddr_reg[VADDR_W-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = ONE_FX;
        div_req.divisor  = DEG_W'(n);

        case (state_reg)
            S_CLR:
            begin
                deg_we  = 1'b1;
                rank_we = 1'b1;
                if (vaddr_reg == VCNT_W'(MAX_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                deg_raddr  = src_vertex;
                rank_raddr = src_vertex;
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_CLEAR:    state_next = S_DCLR;
                        CMD_ADD_EDGE: state_next = S_EDGE;
                        CMD_RUN:
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_INIT;
                        end
                        CMD_READ:     state_next = S_READ;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_DCLR:
            begin
                deg_we = 1'b1;
                if (vaddr_reg == VCNT_W'(MAX_VERTICES - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_EDGE:
            begin
                if (({1'b0, src_reg} < n) && ({1'b0, dst_reg} < n) &&
                    (edge_total_reg != ETOT_W'(MAX_EDGES)))
                begin
                    edge_we   = 1'b1;
                    deg_we    = 1'b1;
                    deg_waddr = src_reg;
                    deg_wdata = (deg_rdata == DEG_MAX) ? DEG_MAX : deg_rdata + 1'b1;
                end
                state_next = S_FIN;
            end
            S_READ:
            begin
                state_next = S_FIN;
            end
            S_INIT:
            begin
                if (div_done)
                begin
                    state_next = S_INITZ;
                end
            end
            S_INITZ:
            begin
                state_next = S_INITW;
            end
            S_INITW:
            begin
                rank_we    = 1'b1;
                rank_wdata = (vaddr_reg < n) ? y_reg : '0;
                if (vaddr_reg == VCNT_W'(MAX_VERTICES - 1))
                begin
                    state_next = (iter_reg == '0) ? S_FIN : S_ARD;
                end
            end
            S_ARD:
            begin
                state_next = S_ASTART;
            end
            S_ASTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = rank_rdata;
                div_req.divisor  = deg_rdata;
                state_next       = S_AWAIT;
            end
            S_AWAIT:
            begin
                if (div_done)
                begin
                    // A vertex with no out-edges contributes nothing
                    rank_we    = 1'b1;
                    rank_wdata = (deg_rdata == '0) ? '0 : div_q;
                    sum_we     = 1'b1;
                    if (!v_last)
                    begin
                        state_next = S_ARD;
                    end
                    else if (edge_total_reg == '0)
                    begin
                        state_next = S_CRD;
                    end
                    else
                    begin
                        state_next = S_BRD;
                    end
                end
            end
            S_BRD:
            begin
                state_next = S_BADR;
            end
            S_BADR:
            begin
                rank_raddr = e_src;
                sum_raddr  = e_dst;
                if (edge_ok)
                begin
                    state_next = S_BUPD;
                end
                else
                begin
                    state_next = e_last ? S_CRD : S_BRD;
                end
            end
            S_BUPD:
            begin
                sum_we     = 1'b1;
                sum_waddr  = t_reg;
                sum_wdata  = sat_one({1'b0, sum_rdata} + {1'b0, rank_rdata});
                state_next = e_last ? S_CRD : S_BRD;
            end
            S_CRD:
            begin
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                rank_we    = 1'b1;
                rank_wdata = sat_one({1'b0, prod_reg[RANK_W+DAMP_W-1:DAMP_W]} +
                                     {1'b0, z_reg});
                if (!v_last)
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = (it_left_reg == ITER_W'(1)) ? S_FIN : S_ARD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Counters and edge total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vaddr_reg      <= '0;
            eaddr_reg      <= '0;
            edge_total_reg <= '0;
            it_left_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLR, S_DCLR, S_INITW:
                begin
                    vaddr_reg <= (vaddr_reg == VCNT_W'(MAX_VERTICES - 1)) ? '0 :
                                 vaddr_reg + 1'b1;
                    if (state_reg == S_INITW)
                    begin
                        it_left_reg <= iter_reg;
                    end
                end
                S_IDLE:
                begin
                    vaddr_reg <= '0;
                    if (accept && (cmd_t'(cmd) == CMD_CLEAR))
                    begin
                        edge_total_reg <= '0;
                    end
                end
                S_EDGE:
                begin
                    if (edge_we)
                    begin
                        edge_total_reg <= edge_total_reg + 1'b1;
                    end
                end
                S_AWAIT:
                begin
                    if (div_done)
                    begin
                        vaddr_reg <= v_last ? '0 : vaddr_reg + 1'b1;
                        eaddr_reg <= '0;
                    end
                end
                S_BADR:
                begin
                    if (!edge_ok)
                    begin
                        eaddr_reg <= eaddr_reg + 1'b1;
                    end
                end
                S_BUPD:
                begin
                    eaddr_reg <= eaddr_reg + 1'b1;
                end
                S_CWR:
                begin
                    vaddr_reg <= v_last ? '0 : vaddr_reg + 1'b1;
                    if (v_last)
                    begin
                        it_left_reg <= it_left_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item capture, run constants and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg        <= src_vertex;
            dst_reg        <= dst_vertex;
            res_status_reg <= ST_OK;
            res_rank_reg   <= '0;
        end
        if (state_reg == S_EDGE)
        begin
            if (!(({1'b0, src_reg} < n) && ({1'b0, dst_reg} < n)))
            begin
                res_status_reg <= ST_RANGE;
            end
            else if (edge_total_reg == ETOT_W'(MAX_EDGES))
            begin
                res_status_reg <= ST_FULL;
            end
        end
        if (state_reg == S_READ)
        begin
            if ({1'b0, src_reg} < n)
            begin
                res_rank_reg <= rank_rdata;
            end
            else
            begin
                res_status_reg <= ST_RANGE;
            end
        end
        if ((state_reg == S_INIT) && div_done)
        begin
            y_reg <= div_q;
        end
        if (state_reg == S_INITZ)
        begin
            z_reg <= zprod[RANK_W+DAMP_W-1:DAMP_W];
        end
        if (state_reg == S_BADR)
        begin
            t_reg <= e_dst;
        end
        if (state_reg == S_CMUL)
        begin
            prod_reg <= sum_rdata * damp_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FIN) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            status_reg <= res_status_reg;
            vertex_reg <= src_reg;
            rank_reg   <= res_rank_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign vertex    = vertex_reg;
    assign rank      = rank_reg;

    // Edge store: source in the upper half, target in the lower
    prs_ram #(
        .WIDTH (2*VID_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_mem (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_total_reg[EADDR_W-1:0]),
        .wdata ({src_reg, dst_reg}),
        .raddr (eaddr_reg[EADDR_W-1:0]),
        .rdata (edge_rdata)
    );

    prs_ram #(
        .WIDTH (DEG_W),
        .DEPTH (MAX_VERTICES)
    ) u_deg_mem (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // Holds ranks, and per-vertex contributions while edges are scattered
    prs_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_VERTICES)
    ) u_rank_mem (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rank_waddr),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    prs_ram #(
        .WIDTH (RANK_W),
        .DEPTH (MAX_VERTICES)
    ) u_sum_mem (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    prs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

`ifndef ASSERT_OFF
    a_sum_sat: assert property (@(posedge clk) disable iff (!rst_n)
        sum_we |-> (sum_wdata <= ONE_FX))
        else $error("rank sum above 1.0");

    a_rank_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rank_we |-> (rank_wdata <= ONE_FX))
        else $error("rank above 1.0");

    a_edge_total: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ETOT_W'(MAX_EDGES))
        else $error("edge total beyond store");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second transfer taken before work done");
`endif

endmodule

/* rtl/prs_ram.sv */
module prs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/prs_div.sv */
module prs_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  prs_pkg::div_req_t        req,
    output logic                     busy,
    output logic                     done,
    output logic [prs_pkg::RANK_W-1:0] quotient
);
    import prs_pkg::*;

    localparam int CNT_W = $clog2(RANK_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(RANK_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RANK_W-1:0] quo_reg;
    logic [DEG_W-1:0] rem_reg;
    logic [DEG_W-1:0] dvs_reg;
    logic [DEG_W:0]   rem_sh;
    logic [DEG_W:0]   diff;
    logic             ge;

    // One quotient bit per cycle, restoring form
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[RANK_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = (rem_sh >= {1'b0, dvs_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= LAST_BIT;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[RANK_W-2:0], ge};
            rem_reg <= ge ? diff[DEG_W-1:0] : rem_sh[DEG_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
